[design/tlrq_pkg.sv]
// tlrq_pkg: shared constants, codes and types of the three-level ready queue scheduler
// used by tlrq_ctrl, three_level_ready_queue_scheduler and tlrq_checker
`default_nettype none

package tlrq_pkg;

    localparam int NUM_PROCS   = 32;
    localparam int PID_W       = 5;
    localparam int CNT_W       = $clog2(NUM_PROCS + 1);
    localparam int NUM_CLASSES = 3;

    typedef logic [PID_W-1:0] t_pid;
    typedef logic [CNT_W-1:0] t_cnt;

    localparam logic [2:0] REQ_READY   = 3'd0;
    localparam logic [2:0] REQ_UNREADY = 3'd1;
    localparam logic [2:0] REQ_PICK    = 3'd2;
    localparam logic [2:0] REQ_ROTATE  = 3'd3;
    localparam logic [2:0] REQ_STOP    = 3'd4;

    localparam logic [1:0] CLS_TASK   = 2'd0;
    localparam logic [1:0] CLS_SERVER = 2'd1;
    localparam logic [1:0] CLS_USER   = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_HEAD_RD,
        ST_WALK_RD,
        ST_UNLINK,
        ST_ROT_RD,
        ST_PICK,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [2:0] req_type;
        t_pid       pid;
        logic [1:0] cls;
    } t_req;

    typedef struct packed {
        t_pid running;
        t_pid billed;
        logic idle;
    } t_result;

endpackage

`default_nettype wire

[design/tlrq_ctrl.sv]
// tlrq_ctrl: request sequencer, queue head/tail registers and the link memory
// depends on tlrq_pkg
`default_nettype none

module tlrq_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire tlrq_pkg::t_req    i_req,
    input  wire tlrq_pkg::t_pid    i_idle_proc,
    input  wire logic              i_take,
    output logic                   o_busy,
    output logic                   o_done,
    output tlrq_pkg::t_result      o_result
);

    tlrq_pkg::t_state r_state, n_state;
    tlrq_pkg::t_req   r_req, n_req;
    logic [tlrq_pkg::NUM_CLASSES-1:0] r_hv, n_hv;
    tlrq_pkg::t_pid   r_head [tlrq_pkg::NUM_CLASSES];
    tlrq_pkg::t_pid   n_head [tlrq_pkg::NUM_CLASSES];
    tlrq_pkg::t_pid   r_tail [tlrq_pkg::NUM_CLASSES];
    tlrq_pkg::t_pid   n_tail [tlrq_pkg::NUM_CLASSES];
    tlrq_pkg::t_pid   r_cur, n_cur;
    tlrq_pkg::t_pid   r_bill, n_bill;
    logic             r_idle, n_idle;
    tlrq_pkg::t_pid   r_prev, n_prev;
    tlrq_pkg::t_cnt   r_cnt, n_cnt;

    tlrq_pkg::t_pid   link_mem [tlrq_pkg::NUM_PROCS];
    tlrq_pkg::t_pid   r_rdata;
    logic             mem_we, mem_re;
    tlrq_pkg::t_pid   mem_wa, mem_wd, mem_ra;

    tlrq_pkg::t_pid   pk_cur, pk_bill;
    logic             pk_idle;
    logic             cls_ok;
    logic [1:0]       c;
    tlrq_pkg::t_pid   p;

    // link memory, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            link_mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_rdata <= link_mem[mem_ra];
        end
    end

    // priority pick over the three queues
    always_comb begin
        pk_bill = r_bill;
        pk_idle = 1'b0;
        if (r_hv[tlrq_pkg::CLS_TASK]) begin
            pk_cur = r_head[tlrq_pkg::CLS_TASK];
        end else if (r_hv[tlrq_pkg::CLS_SERVER]) begin
            pk_cur = r_head[tlrq_pkg::CLS_SERVER];
        end else if (r_hv[tlrq_pkg::CLS_USER]) begin
            pk_cur  = r_head[tlrq_pkg::CLS_USER];
            pk_bill = r_head[tlrq_pkg::CLS_USER];
        end else begin
            pk_cur  = i_idle_proc;
            pk_bill = i_idle_proc;
            pk_idle = 1'b1;
        end
    end

    assign c      = r_req.cls;
    assign p      = r_req.pid;
    assign cls_ok = (c != 2'd3) && (32'(p) < 32'(tlrq_pkg::NUM_PROCS));

    always_comb begin
        n_state = r_state;
        n_req   = r_req;
        n_hv    = r_hv;
        n_head  = r_head;
        n_tail  = r_tail;
        n_cur   = r_cur;
        n_bill  = r_bill;
        n_idle  = r_idle;
        n_prev  = r_prev;
        n_cnt   = r_cnt;
        mem_we  = 1'b0;
        mem_wa  = r_prev;
        mem_wd  = r_rdata;
        mem_re  = 1'b0;
        mem_ra  = p;
        o_done  = 1'b0;
        case (r_state)
            tlrq_pkg::ST_IDLE: begin
                if (i_start) begin
                    n_req   = i_req;
                    n_state = tlrq_pkg::ST_EXEC;
                end
            end
            tlrq_pkg::ST_EXEC: begin
                n_state = tlrq_pkg::ST_DONE;
                case (r_req.req_type)
                    tlrq_pkg::REQ_READY: begin
                        if (cls_ok) begin
                            if (!r_hv[c]) begin
                                n_hv[c]   = 1'b1;
                                n_head[c] = p;
                                n_tail[c] = p;
                                n_cur     = p;
                                n_idle    = 1'b0;
                            end else if (c == tlrq_pkg::CLS_USER) begin
                                mem_we    = 1'b1;
                                mem_wa    = p;
                                mem_wd    = r_head[c];
                                n_head[c] = p;
                            end else begin
                                mem_we    = 1'b1;
                                mem_wa    = r_tail[c];
                                mem_wd    = p;
                                n_tail[c] = p;
                            end
                        end
                    end
                    tlrq_pkg::REQ_UNREADY: begin
                        if (cls_ok && r_hv[c]) begin
                            if (r_head[c] == p) begin
                                if (r_tail[c] == p) begin
                                    n_hv[c] = 1'b0;
                                    if (r_cur == p) begin
                                        n_state = tlrq_pkg::ST_PICK;
                                    end
                                end else begin
                                    mem_re  = 1'b1;
                                    mem_ra  = p;
                                    n_state = tlrq_pkg::ST_HEAD_RD;
                                end
                            end else if (r_head[c] != r_tail[c]) begin
                                mem_re  = 1'b1;
                                mem_ra  = r_head[c];
                                n_prev  = r_head[c];
                                n_cnt   = tlrq_pkg::CNT_W'(1);
                                n_state = tlrq_pkg::ST_WALK_RD;
                            end
                        end
                    end
                    tlrq_pkg::REQ_PICK: begin
                        n_state = tlrq_pkg::ST_PICK;
                    end
                    tlrq_pkg::REQ_ROTATE: begin
                        if (r_hv[tlrq_pkg::CLS_USER]) begin
                            if (r_head[tlrq_pkg::CLS_USER] == r_tail[tlrq_pkg::CLS_USER]) begin
                                n_state = tlrq_pkg::ST_PICK;
                            end else begin
                                mem_re  = 1'b1;
                                mem_ra  = r_head[tlrq_pkg::CLS_USER];
                                mem_we  = 1'b1;
                                mem_wa  = r_tail[tlrq_pkg::CLS_USER];
                                mem_wd  = r_head[tlrq_pkg::CLS_USER];
                                n_tail[tlrq_pkg::CLS_USER] = r_head[tlrq_pkg::CLS_USER];
                                n_state = tlrq_pkg::ST_ROT_RD;
                            end
                        end
                    end
                    tlrq_pkg::REQ_STOP: begin
                        n_hv[tlrq_pkg::CLS_USER] = 1'b0;
                    end
                    default: begin
                        n_state = tlrq_pkg::ST_DONE;
                    end
                endcase
            end
            tlrq_pkg::ST_HEAD_RD: begin
                n_head[c] = r_rdata;
                n_state   = (r_cur == p) ? tlrq_pkg::ST_PICK : tlrq_pkg::ST_DONE;
            end
            tlrq_pkg::ST_WALK_RD: begin
                // r_rdata is the successor of r_prev
                if (r_rdata == p) begin
                    if (r_tail[c] == p) begin
                        n_tail[c] = r_prev;
                        n_state   = tlrq_pkg::ST_DONE;
                    end else begin
                        mem_re  = 1'b1;
                        mem_ra  = p;
                        n_state = tlrq_pkg::ST_UNLINK;
                    end
                end else if (r_rdata == r_tail[c] ||
                             r_cnt == tlrq_pkg::CNT_W'(tlrq_pkg::NUM_PROCS)) begin
                    n_state = tlrq_pkg::ST_DONE;
                end else begin
                    mem_re = 1'b1;
                    mem_ra = r_rdata;
                    n_prev = r_rdata;
                    n_cnt  = r_cnt + tlrq_pkg::CNT_W'(1);
                end
            end
            tlrq_pkg::ST_UNLINK: begin
                mem_we  = 1'b1;
                mem_wa  = r_prev;
                mem_wd  = r_rdata;
                n_state = tlrq_pkg::ST_DONE;
            end
            tlrq_pkg::ST_ROT_RD: begin
                n_head[tlrq_pkg::CLS_USER] = r_rdata;
                n_state = tlrq_pkg::ST_PICK;
            end
            tlrq_pkg::ST_PICK: begin
                n_cur   = pk_cur;
                n_bill  = pk_bill;
                n_idle  = pk_idle;
                n_state = tlrq_pkg::ST_DONE;
            end
            tlrq_pkg::ST_DONE: begin
                o_done = 1'b1;
                if (i_take) begin
                    n_state = tlrq_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = tlrq_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tlrq_pkg::ST_IDLE;
            r_hv    <= '0;
            r_head  <= '{default: '0};
            r_tail  <= '{default: '0};
            r_cur   <= '0;
            r_bill  <= '0;
            r_idle  <= 1'b1;
        end else begin
            r_state <= n_state;
            r_hv    <= n_hv;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_cur   <= n_cur;
            r_bill  <= n_bill;
            r_idle  <= n_idle;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req  <= n_req;
        r_prev <= n_prev;
        r_cnt  <= n_cnt;
    end

    assign o_busy   = (r_state != tlrq_pkg::ST_IDLE);
    assign o_result = '{running: r_cur, billed: r_bill, idle: r_idle};

endmodule

`default_nettype wire

[design/three_level_ready_queue_scheduler.sv]
// three_level_ready_queue_scheduler: top level with handshakes, idle process register
// and result register; depends on tlrq_pkg and tlrq_ctrl
`default_nettype none

// Scheduler over three linked ready queues (task, server, user) of 32 process ids.
// One request is taken at a time and gives one result: the running process, the
// billed process and whether the idle process runs, as they stand after the request.
// Unready of an entry other than the head walks its queue through the single read
// port of the link memory, one link per cycle. A new request is taken while the
// previous result still waits in the output register. The link memory needs no
// clearing after reset.
module three_level_ready_queue_scheduler (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_in_valid,
    output logic                        o_in_stall,
    input  wire logic [2:0]             i_req_type,
    input  wire tlrq_pkg::t_pid         i_proc_id,
    input  wire logic [1:0]             i_proc_class,
    output logic                        o_out_valid,
    input  wire logic                   i_out_stall,
    output tlrq_pkg::t_pid              o_running_proc,
    output tlrq_pkg::t_pid              o_billed_proc,
    output logic                        o_idle_selected,
    input  wire logic                   i_cfg_we,
    input  wire tlrq_pkg::t_pid         i_cfg_data
);

    tlrq_pkg::t_pid    r_idle_proc;
    logic              r_out_valid;
    tlrq_pkg::t_result r_out;
    tlrq_pkg::t_result ctrl_result;
    tlrq_pkg::t_req    req;
    logic              busy, done, take;

    assign req  = '{req_type: i_req_type, pid: i_proc_id, cls: i_proc_class};
    assign take = !r_out_valid || !i_out_stall;

    tlrq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_in_valid),
        .i_req       (req),
        .i_idle_proc (r_idle_proc),
        .i_take      (take),
        .o_busy      (busy),
        .o_done      (done),
        .o_result    (ctrl_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idle_proc <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_idle_proc <= i_cfg_data;
            end
            if (done && take) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (done && take) begin
            r_out <= ctrl_result;
        end
    end

    assign o_in_stall      = busy;
    assign o_out_valid     = r_out_valid;
    assign o_running_proc  = r_out.running;
    assign o_billed_proc   = r_out.billed;
    assign o_idle_selected = r_out.idle;

endmodule

`default_nettype wire

[design/tlrq_checker.sv]
// tlrq_checker: port-level checks of the scheduler, bound to the top level
// depends on tlrq_pkg and three_level_ready_queue_scheduler
`default_nettype none

module tlrq_checker (
    input wire logic           i_clk,
    input wire logic           i_rst_n,
    input wire logic           i_in_valid,
    input wire logic           o_in_stall,
    input wire logic           o_out_valid,
    input wire logic           i_out_stall,
    input wire tlrq_pkg::t_pid o_running_proc,
    input wire tlrq_pkg::t_pid o_billed_proc,
    input wire logic           o_idle_selected
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_running_proc)
            && $stable(o_billed_proc) && $stable(o_idle_selected))
        else $error("stalled result changed");

    // no result right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // one request in flight
    a_busy_after_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second transfer before request done");

    // idle process runs and is billed
    a_idle_billed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_idle_selected |-> o_running_proc == o_billed_proc)
        else $error("idle selected but billed process differs");

endmodule

bind three_level_ready_queue_scheduler tlrq_checker u_tlrq_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in_valid),
    .o_in_stall      (o_in_stall),
    .o_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .o_running_proc  (o_running_proc),
    .o_billed_proc   (o_billed_proc),
    .o_idle_selected (o_idle_selected)
);

`default_nettype wire

[bench/tlrq_checker.sv]
// tlrq_tb_checker: watches the request, result and idle-process register ports of the
// three-level ready queue scheduler, predicts each status and compares it on transfer
// depends on tlrq_pkg
module tlrq_tb_checker
    import tlrq_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    input  wire logic       i_in_stall,
    input  wire logic [2:0] i_req_type,
    input  wire t_pid       i_proc_id,
    input  wire logic [1:0] i_proc_class,
    input  wire logic       i_out_valid,
    input  wire logic       i_out_stall,
    input  wire t_pid       i_running_proc,
    input  wire t_pid       i_billed_proc,
    input  wire logic       i_idle_selected,
    input  wire logic       i_cfg_we,
    input  wire t_pid       i_cfg_data,
    output int              o_fail_count,
    output int              o_pending,
    output int              o_checked
);

    t_pid    link_tbl [NUM_PROCS];
    logic    q_on     [NUM_CLASSES];
    t_pid    q_first  [NUM_CLASSES];
    t_pid    q_last   [NUM_CLASSES];
    t_pid    run_pid;
    t_pid    bill_pid;
    t_pid    idle_pid;
    logic    on_idle;
    t_result status_q [$];

    function automatic void choose_run();
        for (int c = 0; c < NUM_CLASSES; c++) begin
            if (q_on[c]) begin
                run_pid = q_first[c];
                if (c == CLS_USER) begin
                    bill_pid = q_first[c];
                end
                on_idle = 1'b0;
                return;
            end
        end
        run_pid  = idle_pid;
        bill_pid = idle_pid;
        on_idle  = 1'b1;
    endfunction

    function automatic void link_in(logic [1:0] cl, t_pid p);
        if (!q_on[cl]) begin
            q_on[cl]    = 1'b1;
            q_first[cl] = p;
            q_last[cl]  = p;
            run_pid     = p;
            on_idle     = 1'b0;
        end else if (cl == CLS_USER) begin
            link_tbl[p] = q_first[cl];
            q_first[cl] = p;
        end else begin
            link_tbl[q_last[cl]] = p;
            q_last[cl]           = p;
        end
    endfunction

    function automatic void unlink(logic [1:0] cl, t_pid p);
        t_pid prev;
        t_pid nxt;
        if (!q_on[cl]) begin
            return;
        end
        if (q_first[cl] == p) begin
            if (q_last[cl] == p) begin
                q_on[cl] = 1'b0;
            end else begin
                q_first[cl] = link_tbl[p];
            end
            if (run_pid == p) begin
                choose_run();
            end
            return;
        end
        prev = q_first[cl];
        for (int n = 0; n < NUM_PROCS; n++) begin
            if (prev == q_last[cl]) begin
                return;
            end
            nxt = link_tbl[prev];
            if (nxt == p) begin
                if (q_last[cl] == p) begin
                    q_last[cl] = prev;
                end else begin
                    link_tbl[prev] = link_tbl[p];
                end
                return;
            end
            prev = nxt;
        end
    endfunction

    function automatic void rotate_user();
        t_pid h;
        if (!q_on[CLS_USER]) begin
            return;
        end
        h = q_first[CLS_USER];
        if (h != q_last[CLS_USER]) begin
            q_first[CLS_USER]          = link_tbl[h];
            link_tbl[q_last[CLS_USER]] = h;
            q_last[CLS_USER]           = h;
        end
        choose_run();
    endfunction

    function automatic t_result advance_sched(logic [2:0] rq, t_pid p, logic [1:0] cl);
        t_result r;
        case (rq)
            REQ_READY: begin
                if (cl < NUM_CLASSES) begin
                    link_in(cl, p);
                end
            end
            REQ_UNREADY: begin
                if (cl < NUM_CLASSES) begin
                    unlink(cl, p);
                end
            end
            REQ_PICK:   choose_run();
            REQ_ROTATE: rotate_user();
            REQ_STOP:   q_on[CLS_USER] = 1'b0;
            default: ;
        endcase
        r.running = run_pid;
        r.billed  = bill_pid;
        r.idle    = on_idle;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_PROCS; i++) begin
                link_tbl[i] = '0;
            end
            for (int c = 0; c < NUM_CLASSES; c++) begin
                q_on[c]    = 1'b0;
                q_first[c] = '0;
                q_last[c]  = '0;
            end
            run_pid      = '0;
            bill_pid     = '0;
            idle_pid     = '0;
            on_idle      = 1'b1;
            status_q.delete();
            o_fail_count = 0;
            o_pending    = 0;
            o_checked    = 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                o_checked++;
                if (status_q.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10) begin
                        $display("unexpected status: run %0d bill %0d idle %0d",
                                 i_running_proc, i_billed_proc, i_idle_selected);
                    end
                end else begin
                    want = status_q.pop_front();
                    if (want.running !== i_running_proc || want.billed !== i_billed_proc
                            || want.idle !== i_idle_selected) begin
                        o_fail_count++;
                        if (o_fail_count <= 10) begin
                            $display("status %0d mismatch: expected run %0d bill %0d idle %0d",
                                     o_checked, want.running, want.billed, want.idle,
                                     ", got run %0d bill %0d idle %0d",
                                     i_running_proc, i_billed_proc, i_idle_selected);
                        end
                    end
                end
            end
            if (i_cfg_we) begin
                idle_pid = i_cfg_data;
            end
            if (i_in_valid && !i_in_stall) begin
                status_q.push_back(advance_sched(i_req_type, i_proc_id, i_proc_class));
            end
            o_pending = status_q.size();
        end
    end

endmodule

[bench/three_level_ready_queue_scheduler_tb.sv]
// three_level_ready_queue_scheduler_tb: drives directed and random scheduler requests,
// idle-process register writes and output stalls, and reports the verdict
// depends on tlrq_pkg, three_level_ready_queue_scheduler and tlrq_tb_checker
module three_level_ready_queue_scheduler_tb;
    import tlrq_pkg::*;

    localparam int          CYCLE_LIMIT   = 1000000;
    localparam int          HOLD_AT       = 1400;
    localparam int          HOLD_LEN      = 300;
    localparam int          DRAIN_CYCLES  = 40;
    localparam logic [2:0]  REQ_FIRST_BAD = 3'd5;
    localparam logic [2:0]  REQ_LAST_BAD  = 3'd7;
    localparam logic [1:0]  CLS_BAD       = 2'd3;
    localparam logic [1:0]  NOT_QUEUED    = 2'd3;

    logic       clk        = 1'b0;
    logic       rst_n      = 1'b0;
    logic       in_valid   = 1'b0;
    logic       in_stall;
    logic [2:0] req_type   = REQ_PICK;
    t_pid       proc_id    = '0;
    logic [1:0] proc_class = CLS_TASK;
    logic       out_valid;
    logic       out_stall  = 1'b0;
    t_pid       running_proc;
    t_pid       billed_proc;
    logic       idle_selected;
    logic       cfg_we     = 1'b0;
    t_pid       cfg_data   = '0;

    int fail_count;
    int pending;
    int checked;
    int n_cycles  = 0;
    int n_sent    = 0;
    int gap_pct   = 0;
    int stall_pct = 0;
    int req_seen  [8];
    logic [1:0] queued_in  [NUM_PROCS];
    int         queued_cnt [NUM_CLASSES];

    three_level_ready_queue_scheduler u_top (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .o_in_stall      (in_stall),
        .i_req_type      (req_type),
        .i_proc_id       (proc_id),
        .i_proc_class    (proc_class),
        .o_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .o_running_proc  (running_proc),
        .o_billed_proc   (billed_proc),
        .o_idle_selected (idle_selected),
        .i_cfg_we        (cfg_we),
        .i_cfg_data      (cfg_data)
    );

    tlrq_tb_checker u_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .i_in_stall      (in_stall),
        .i_req_type      (req_type),
        .i_proc_id       (proc_id),
        .i_proc_class    (proc_class),
        .i_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .i_running_proc  (running_proc),
        .i_billed_proc   (billed_proc),
        .i_idle_selected (idle_selected),
        .i_cfg_we        (cfg_we),
        .i_cfg_data      (cfg_data),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_checked       (checked)
    );

    initial begin
        forever #2 clk = ~clk;
    end

    initial begin
        while (n_cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            n_cycles++;
        end
        $display("Verification failed");
        $finish;
    end

    // receiver stalls, with one long hold-off late in the run
    initial begin
        int  hold_left;
        bit  hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        forever begin
            @(posedge clk);
            if (hold_left > 0) begin
                out_stall <= 1'b1;
                hold_left--;
            end else if (!hold_done && n_sent >= HOLD_AT) begin
                hold_done = 1'b1;
                hold_left = HOLD_LEN;
                out_stall <= 1'b1;
            end else begin
                out_stall <= ($urandom_range(0, 99) < stall_pct);
            end
        end
    end

    // which queue each id sits in, so that no link is followed before it is written
    function automatic void track_queues(logic [2:0] rq, t_pid p, logic [1:0] cl);
        case (rq)
            REQ_READY: begin
                if (cl != CLS_BAD && queued_in[p] == NOT_QUEUED) begin
                    queued_in[p] = cl;
                    queued_cnt[cl]++;
                end
            end
            REQ_UNREADY: begin
                if (cl != CLS_BAD && queued_in[p] == cl) begin
                    queued_in[p] = NOT_QUEUED;
                    queued_cnt[cl]--;
                end
            end
            REQ_STOP: begin
                for (int i = 0; i < NUM_PROCS; i++) begin
                    if (queued_in[i] == CLS_USER) begin
                        queued_in[i] = NOT_QUEUED;
                    end
                end
                queued_cnt[CLS_USER] = 0;
            end
            default: ;
        endcase
    endfunction

    function automatic int find_proc(logic [1:0] want);
        int start;
        start = $urandom_range(0, NUM_PROCS - 1);
        for (int k = 0; k < NUM_PROCS; k++) begin
            if (queued_in[(start + k) % NUM_PROCS] == want) begin
                return (start + k) % NUM_PROCS;
            end
        end
        return -1;
    endfunction

    task automatic make_req(output logic [2:0] rq, output t_pid p, output logic [1:0] cl);
        int roll;
        int hit;
        roll = $urandom_range(0, 99);
        rq   = REQ_PICK;
        p    = t_pid'($urandom);
        cl   = 2'($urandom_range(0, 3));
        if (roll < 36) begin
            hit = find_proc(NOT_QUEUED);
            if (hit >= 0) begin
                rq = REQ_READY;
                p  = t_pid'(hit);
                cl = 2'($urandom_range(0, 2));
            end
        end else if (roll < 40) begin
            // ready again the only entry of a queue
            cl = 2'($urandom_range(0, 2));
            if (queued_cnt[cl] == 1) begin
                rq = REQ_READY;
                p  = t_pid'(find_proc(cl));
            end
        end else if (roll < 64) begin
            cl  = 2'($urandom_range(0, 2));
            hit = find_proc(cl);
            if (hit >= 0) begin
                rq = REQ_UNREADY;
                p  = t_pid'(hit);
            end
        end else if (roll < 69) begin
            rq = REQ_UNREADY;
            cl = 2'($urandom_range(0, 2));
        end else if (roll < 81) begin
            rq = REQ_PICK;
        end else if (roll < 92) begin
            rq = REQ_ROTATE;
        end else if (roll < 95) begin
            rq = REQ_STOP;
        end else if (roll < 97) begin
            rq = 3'($urandom_range(REQ_FIRST_BAD, REQ_LAST_BAD));
        end else begin
            rq = $urandom_range(0, 1) ? REQ_READY : REQ_UNREADY;
            cl = CLS_BAD;
        end
    endtask

    task automatic send_req(input logic [2:0] rq, input t_pid p, input logic [1:0] cl);
        while ($urandom_range(0, 99) < gap_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        req_type   <= rq;
        proc_id    <= p;
        proc_class <= cl;
        @(posedge clk);
        while (in_stall) begin
            @(posedge clk);
        end
        n_sent <= n_sent + 1;
        req_seen[rq]++;
        track_queues(rq, p, cl);
    endtask

    task automatic wait_results();
        in_valid <= 1'b0;
        do begin
            @(negedge clk);
        end while (pending != 0);
        @(posedge clk);
    endtask

    task automatic set_idle_proc(input t_pid v);
        cfg_data <= v;
        cfg_we   <= 1'b1;
        @(posedge clk);
        cfg_we   <= 1'b0;
    endtask

    task automatic run_phase(input int n_items, input int gap, input int stall,
                             input t_pid idle_v);
        logic [2:0] rq;
        t_pid       p;
        logic [1:0] cl;
        wait_results();
        set_idle_proc(idle_v);
        gap_pct   = gap;
        stall_pct = stall;
        repeat (n_items) begin
            make_req(rq, p, cl);
            send_req(rq, p, cl);
        end
    endtask

    initial begin
        for (int i = 0; i < NUM_PROCS; i++) begin
            queued_in[i] = NOT_QUEUED;
        end
        for (int c = 0; c < NUM_CLASSES; c++) begin
            queued_cnt[c] = 0;
        end
        for (int r = 0; r < 8; r++) begin
            req_seen[r] = 0;
        end
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        set_idle_proc(5'd31);
        gap_pct   = 20;
        stall_pct = 30;

        send_req(REQ_PICK, 5'd0, CLS_TASK);
        send_req(REQ_LAST_BAD, 5'd31, CLS_BAD);
        send_req(REQ_READY, 5'd5, CLS_BAD);
        send_req(REQ_UNREADY, 5'd0, CLS_TASK);
        send_req(REQ_ROTATE, 5'd31, CLS_BAD);
        send_req(REQ_READY, 5'd31, CLS_USER);
        send_req(REQ_READY, 5'd0, CLS_TASK);
        send_req(REQ_READY, 5'd7, CLS_TASK);
        send_req(REQ_READY, 5'd9, CLS_TASK);
        send_req(REQ_READY, 5'd12, CLS_SERVER);
        send_req(REQ_READY, 5'd20, CLS_USER);
        send_req(REQ_READY, 5'd3, CLS_USER);
        send_req(REQ_UNREADY, 5'd9, CLS_TASK);
        send_req(REQ_UNREADY, 5'd15, CLS_TASK);
        send_req(REQ_UNREADY, 5'd0, CLS_TASK);
        send_req(REQ_PICK, 5'd21, CLS_SERVER);
        send_req(REQ_ROTATE, 5'd10, CLS_USER);
        send_req(REQ_UNREADY, 5'd7, CLS_TASK);
        send_req(REQ_UNREADY, 5'd12, CLS_SERVER);
        send_req(REQ_ROTATE, 5'd0, CLS_TASK);
        send_req(REQ_UNREADY, 5'd3, CLS_USER);
        send_req(REQ_UNREADY, 5'd20, CLS_USER);
        send_req(REQ_READY, 5'd31, CLS_USER);
        send_req(REQ_ROTATE, 5'd31, CLS_USER);
        send_req(REQ_STOP, 5'd31, CLS_USER);
        send_req(REQ_PICK, 5'd31, CLS_BAD);
        send_req(REQ_FIRST_BAD, 5'd0, CLS_TASK);

        run_phase(600, 14, 88, 5'd0);
        run_phase(500, 88, 14, t_pid'($urandom_range(1, 30)));
        run_phase(650, 0, 0, t_pid'($urandom));

        wait_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
        $display("run covered %0d requests: %0d ready, %0d unready, %0d pick,",
                 n_sent, req_seen[REQ_READY], req_seen[REQ_UNREADY], req_seen[REQ_PICK],
                 " %0d rotate, %0d stop, %0d undefined",
                 req_seen[REQ_ROTATE], req_seen[REQ_STOP],
                 req_seen[5] + req_seen[6] + req_seen[7]);
        $display("%0d status transfers compared under four idle process settings,",
                 checked, " %0d mismatches", fail_count);
        if (fail_count == 0 && pending == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

[three_level_ready_queue_scheduler.f]
design/tlrq_pkg.sv
design/tlrq_ctrl.sv
design/three_level_ready_queue_scheduler.sv
design/tlrq_checker.sv
bench/tlrq_checker.sv
bench/three_level_ready_queue_scheduler_tb.sv
